// ===== design/zre_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zre_pkg: shared types and constants of the zigzag run-length encoder
// Frame store geometry, field widths, command and register codes.
// ----------------------------------------------------------------------------
package zre_pkg;

  localparam int STORE_COLS = 256;
  localparam int STORE_ROWS = 256;
  localparam int DEPTH      = STORE_COLS * STORE_ROWS;

  localparam int COL_W  = $clog2(STORE_COLS);
  localparam int ROW_W  = $clog2(STORE_ROWS);
  localparam int ADDR_W = $clog2(DEPTH);

  localparam int COEF_W    = 32;
  localparam int RUN_W     = 17;
  localparam int DIM_W     = 9;
  localparam int CFG_IDX_W = 1;

  localparam logic [RUN_W-1:0] RUN_MAX   = {RUN_W{1'b1}};
  localparam logic [DIM_W-1:0] DIM_RESET = 9'd256;

  // Command codes
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

  // One run pair as it leaves the block
  typedef struct packed {
    logic [COEF_W-1:0] value;
    logic [RUN_W-1:0]  length;
    logic              last;
  } run_t;

  // Scan read issued to the run merger
  typedef struct packed {
    logic valid;
    logic last_elem;
  } tick_t;

  // Last index in use for a configured dimension, clamped to [2, max]
  function automatic int last_index(input logic [DIM_W-1:0] dim, input int max_dim);
    int d;
    d = int'(dim);
    if (d < 2) return 1;
    if (d > max_dim) return max_dim - 1;
    return d - 1;
  endfunction

endpackage

// ===== design/zre_frame_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zre_frame_store: coefficient frame memory
// Single-port synchronous memory, one write or one read per cycle, read data
// registered and held until the next read.
// ----------------------------------------------------------------------------
module zre_frame_store (
  input  logic                        clk,
  input  logic                        wr_en,
  input  logic                        rd_en,
  input  logic [zre_pkg::ADDR_W-1:0]  addr,
  input  logic [zre_pkg::COEF_W-1:0]  wdata,
  output logic [zre_pkg::COEF_W-1:0]  rdata
);
  import zre_pkg::*;

  logic [COEF_W-1:0] mem [DEPTH];
  logic [COEF_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== design/zre_walker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zre_walker: load and zigzag address sequencer
// Holds the frame size registers, the raster load position and the zigzag
// scan position, and turns each accepted item into a store access.
// ----------------------------------------------------------------------------
module zre_walker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           accept,
  input  logic                           command,
  input  logic                           cfg_we,
  input  logic [zre_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [zre_pkg::DIM_W-1:0]      cfg_data,
  output logic                           wr_en,
  output logic                           rd_en,
  output logic [zre_pkg::ADDR_W-1:0]     addr,
  output zre_pkg::tick_t                 tick
);
  import zre_pkg::*;

  logic [DIM_W-1:0] fw_r, fw_nxt, fh_r, fh_nxt;
  logic             scanning_r, scanning_nxt;
  logic [ROW_W-1:0] load_row_r, load_row_nxt;
  logic [COL_W-1:0] load_col_r, load_col_nxt;
  logic [ROW_W-1:0] scan_row_r, scan_row_nxt;
  logic [COL_W-1:0] scan_col_r, scan_col_nxt;
  logic             going_up_r, going_up_nxt;

  logic [COL_W-1:0] w_last;
  logic [ROW_W-1:0] h_last;
  logic             do_load, do_tick, scan_end, cfg_ok;
  logic [ROW_W-1:0] row_sel;
  logic [COL_W-1:0] col_sel;

  assign w_last = COL_W'(last_index(fw_r, STORE_COLS));
  assign h_last = ROW_W'(last_index(fh_r, STORE_ROWS));

  assign do_load  = accept && (command == CMD_LOAD) && !scanning_r;
  assign do_tick  = accept && (command == CMD_TICK) && scanning_r;
  assign scan_end = (scan_row_r == h_last) && (scan_col_r == w_last);
  assign cfg_ok   = !scanning_r && (load_row_r == '0) && (load_col_r == '0);

  assign row_sel = scanning_r ? scan_row_r : load_row_r;
  assign col_sel = scanning_r ? scan_col_r : load_col_r;
  assign addr    = ADDR_W'(ADDR_W'(row_sel) * ADDR_W'(STORE_COLS) + ADDR_W'(col_sel));

  assign wr_en          = do_load;
  assign rd_en          = do_tick;
  assign tick.valid     = do_tick;
  assign tick.last_elem = scan_end;

  always_comb begin
    fw_nxt       = fw_r;
    fh_nxt       = fh_r;
    scanning_nxt = scanning_r;
    load_row_nxt = load_row_r;
    load_col_nxt = load_col_r;
    scan_row_nxt = scan_row_r;
    scan_col_nxt = scan_col_r;
    going_up_nxt = going_up_r;

    if (cfg_we && cfg_ok) begin
      case (cfg_index)
        REG_FRAME_WIDTH:  fw_nxt = cfg_data;
        REG_FRAME_HEIGHT: fh_nxt = cfg_data;
        default: ;
      endcase
    end

    if (do_load) begin
      if (load_col_r == w_last) begin
        load_col_nxt = '0;
        if (load_row_r == h_last) begin
          load_row_nxt = '0;
          scanning_nxt = 1'b1;
          scan_row_nxt = '0;
          scan_col_nxt = '0;
          going_up_nxt = 1'b1;
        end else begin
          load_row_nxt = load_row_r + 1'b1;
        end
      end else begin
        load_col_nxt = load_col_r + 1'b1;
      end
    end

    if (do_tick) begin
      if (scan_end) begin
        // back to loading, rewind everything
        scanning_nxt = 1'b0;
        load_row_nxt = '0;
        load_col_nxt = '0;
        scan_row_nxt = '0;
        scan_col_nxt = '0;
        going_up_nxt = 1'b1;
      end else if (going_up_r) begin
        if (scan_col_r < w_last) begin
          scan_col_nxt = scan_col_r + 1'b1;
          if (scan_row_r == '0) going_up_nxt = 1'b0;
          else scan_row_nxt = scan_row_r - 1'b1;
        end else begin
          scan_row_nxt = scan_row_r + 1'b1;
          going_up_nxt = 1'b0;
        end
      end else begin
        if (scan_row_r < h_last) begin
          scan_row_nxt = scan_row_r + 1'b1;
          if (scan_col_r == '0) going_up_nxt = 1'b1;
          else scan_col_nxt = scan_col_r - 1'b1;
        end else begin
          scan_col_nxt = scan_col_r + 1'b1;
          going_up_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r       <= DIM_RESET;
      fh_r       <= DIM_RESET;
      scanning_r <= 1'b0;
      load_row_r <= '0;
      load_col_r <= '0;
      scan_row_r <= '0;
      scan_col_r <= '0;
      going_up_r <= 1'b1;
    end else begin
      fw_r       <= fw_nxt;
      fh_r       <= fh_nxt;
      scanning_r <= scanning_nxt;
      load_row_r <= load_row_nxt;
      load_col_r <= load_col_nxt;
      scan_row_r <= scan_row_nxt;
      scan_col_r <= scan_col_nxt;
      going_up_r <= going_up_nxt;
    end
  end

  a_pos_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    scanning_r |-> (scan_row_r <= h_last) && (scan_col_r <= w_last))
    else $error("scan position outside frame");

  a_load_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    !scanning_r |-> (load_row_r <= h_last) && (load_col_r <= w_last))
    else $error("load position outside frame");

  a_end_leaves_scan: assert property (@(posedge clk) disable iff (!rst_n)
    do_tick && scan_end |=> !scanning_r && (load_row_r == '0) && (load_col_r == '0))
    else $error("final element did not return to loading");

endmodule

// ===== design/zre_run_merge.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zre_run_merge: run-length merge and output queue
// Compares each scanned coefficient with the open run, emits closed runs
// into a two-entry output queue, and holds the scan when the queue is full.
// ----------------------------------------------------------------------------
module zre_run_merge (
  input  logic                        clk,
  input  logic                        rst_n,
  input  zre_pkg::tick_t              tick,
  input  logic [zre_pkg::COEF_W-1:0]  rdata,
  output logic                        hold,
  output logic                        out_valid,
  input  logic                        out_stall,
  output zre_pkg::run_t               out_run
);
  import zre_pkg::*;

  logic              s1_valid_r, s1_valid_nxt;
  logic              s1_last_r, s1_last_nxt;
  logic              first_r, first_nxt;
  logic [COEF_W-1:0] run_cur_r, run_cur_nxt;
  logic [RUN_W-1:0]  run_cnt_r, run_cnt_nxt;
  run_t              q_r [2];
  run_t              q_nxt [2];
  logic [1:0]        q_cnt_r, q_cnt_nxt;

  logic              differ, fire, pop;
  logic [1:0]        n_emit, n_push, cnt_p;
  logic [COEF_W-1:0] new_cur;
  logic [RUN_W-1:0]  new_cnt;
  run_t              closed, final_run, push_a, sh0, sh1;

  assign differ = !first_r && (rdata != run_cur_r);

  always_comb begin
    if (first_r || differ) begin
      new_cur = rdata;
      new_cnt = RUN_W'(1);
    end else begin
      new_cur = run_cur_r;
      new_cnt = (run_cnt_r == RUN_MAX) ? run_cnt_r : run_cnt_r + 1'b1;
    end
  end

  assign closed    = '{value: run_cur_r, length: run_cnt_r, last: 1'b0};
  assign final_run = '{value: new_cur, length: new_cnt, last: 1'b1};
  assign push_a    = differ ? closed : final_run;
  assign n_emit    = {1'b0, differ} + {1'b0, s1_last_r};

  // fire only when the queue can take every result, ignoring this cycle's pop
  assign fire = s1_valid_r && (({1'b0, q_cnt_r} + {1'b0, n_emit}) <= 3'd2);
  assign hold = s1_valid_r && !fire;

  assign out_valid = (q_cnt_r != 2'd0);
  assign out_run   = q_r[0];
  assign pop       = out_valid && !out_stall;

  assign n_push = fire ? n_emit : 2'd0;
  assign cnt_p  = q_cnt_r - {1'b0, pop};
  assign sh0    = pop ? q_r[1] : q_r[0];
  assign sh1    = q_r[1];

  always_comb begin
    q_nxt[0]  = (cnt_p == 2'd0 && n_push != 2'd0) ? push_a : sh0;
    if (cnt_p == 2'd0) q_nxt[1] = final_run;
    else if (cnt_p == 2'd1 && n_push != 2'd0) q_nxt[1] = push_a;
    else q_nxt[1] = sh1;
    q_cnt_nxt = cnt_p + n_push;
  end

  always_comb begin
    s1_valid_nxt = hold ? 1'b1 : tick.valid;
    s1_last_nxt  = hold ? s1_last_r : tick.last_elem;
    first_nxt    = first_r;
    run_cur_nxt  = run_cur_r;
    run_cnt_nxt  = run_cnt_r;
    if (fire) begin
      if (s1_last_r) begin
        // frame done: clear the open run
        first_nxt   = 1'b1;
        run_cur_nxt = '0;
        run_cnt_nxt = '0;
      end else begin
        first_nxt   = 1'b0;
        run_cur_nxt = new_cur;
        run_cnt_nxt = new_cnt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s1_last_r  <= 1'b0;
      first_r    <= 1'b1;
      run_cur_r  <= '0;
      run_cnt_r  <= '0;
      q_cnt_r    <= 2'd0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      s1_last_r  <= s1_last_nxt;
      first_r    <= first_nxt;
      run_cur_r  <= run_cur_nxt;
      run_cnt_r  <= run_cnt_nxt;
      q_cnt_r    <= q_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r[0] <= q_nxt[0];
    q_r[1] <= q_nxt[1];
  end

  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_cnt_r != 2'd3)
    else $error("output queue overflow");

  a_hold_keeps: assert property (@(posedge clk) disable iff (!rst_n)
    hold |=> s1_valid_r && $stable(s1_last_r))
    else $error("held scan element lost");

  a_no_read_on_hold: assert property (@(posedge clk) disable iff (!rst_n)
    tick.valid |-> !hold)
    else $error("store read issued while merge stage held");

  a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_run.length != '0)
    else $error("empty run transferred");

endmodule

// ===== design/zigzag_run_length_encoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zigzag_run_length_encoder: zigzag scan run-length encoder, top level
// Loads a coefficient frame in raster order, then scans it in zigzag order
// and emits (value, run length, last) pairs.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): in_command selects a load
//   (coefficient written in raster order) or a scan tick. Loads during a
//   scan and ticks during loading are dropped with no result.
//   Output channel (out_valid / out_stall): one run pair per transfer; the
//   final pair of a frame has out_frame_last set. The final tick can give
//   two pairs.
//   Configuration: cfg_we writes frame_width (index 0) or frame_height
//   (index 1); a write is taken only while loading and before the first
//   coefficient of a frame. Values are clamped to [2, 256].
//   Pipeline: a tick's read data and scan flags are registered into the merge
//   stage, and the pairs it closes are registered into the output queue.
//   Throughput: one item per cycle, set by the single store port. A tick's
//   pairs enter the two-entry queue only once all of them fit, counted
//   before this cycle's output transfer; until then in_stall holds the input.
//   Reset: frame size returns to 256 x 256 and the block starts loading;
//   the frame store is not cleared (a scan reads only what was loaded).
//   Receiver stall: the output queue fills, then in_stall rises and holds
//   the scan until the queue drains.
// ----------------------------------------------------------------------------
module zigzag_run_length_encoder (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_command,
  input  logic signed [31:0]             in_coefficient,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [31:0]             out_run_value,
  output logic [16:0]                    out_run_length,
  output logic                           out_frame_last,
  input  logic                           cfg_we,
  input  logic [zre_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [zre_pkg::DIM_W-1:0]      cfg_data
);
  import zre_pkg::*;

  logic              accept;
  logic              hold;
  logic              wr_en, rd_en;
  logic [ADDR_W-1:0] addr;
  logic [COEF_W-1:0] rdata;
  tick_t             tick;
  run_t              out_run;

  // transfer on the input channel; the merge stage holds when its queue is full
  assign in_stall = hold;
  assign accept   = in_valid && !in_stall;

  zre_walker u_walker (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .command   (in_command),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .wr_en     (wr_en),
    .rd_en     (rd_en),
    .addr      (addr),
    .tick      (tick)
  );

  zre_frame_store u_store (
    .clk   (clk),
    .wr_en (wr_en),
    .rd_en (rd_en),
    .addr  (addr),
    .wdata (COEF_W'(in_coefficient)),
    .rdata (rdata)
  );

  zre_run_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .tick      (tick),
    .rdata     (rdata),
    .hold      (hold),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_run   (out_run)
  );

  assign out_run_value  = signed'(out_run.value);
  assign out_run_length = out_run.length;
  assign out_frame_last = out_run.last;

endmodule

// ===== tb/zigzag_run_length_encoder_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zigzag_run_length_encoder_tb: self-checking bench for the zigzag RLE block
// Loads coefficient frames, scans them with ticks and checks every run pair
// against an in-bench zigzag/run-length predictor. A short table of directed
// transfers comes first. Random frames of many sizes follow, with
// wrong-phase noise, writes while busy, bursty input and receiver stalls.
// ----------------------------------------------------------------------------
module zigzag_run_length_encoder_tb;
  import zre_pkg::*;

  localparam int SETTLE_CYCLES = 6;     // quiet time after the last owed pair
  localparam int HOLD_CYCLES   = 300;   // long receiver hold-off
  localparam int RANDOM_ITEMS  = 450;

  localparam logic [COEF_W-1:0] INT_MIN = 32'h8000_0000;
  localparam logic [COEF_W-1:0] INT_MAX = 32'h7FFF_FFFF;

  typedef enum logic {ROW_ITEM, ROW_WRITE} row_kind_e;

  // One directed step: an input transfer or a register write.
  // nexp < 0 leaves the expectation to the predictor.
  typedef struct packed {
    row_kind_e   kind;
    logic        sel;    // command for items, register index for writes
    logic [31:0] data;   // coefficient, or register value
    int          nexp;
    run_t        e0;
    run_t        e1;
  } step_row_t;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  logic                 in_command;
  logic signed [31:0]   in_coefficient;
  logic                 out_valid;
  logic                 out_stall;
  logic signed [31:0]   out_run_value;
  logic [16:0]          out_run_length;
  logic                 out_frame_last;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [DIM_W-1:0]     cfg_data;

  zigzag_run_length_encoder u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_command     (in_command),
    .in_coefficient (in_coefficient),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_run_value  (out_run_value),
    .out_run_length (out_run_length),
    .out_frame_last (out_frame_last),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Predictor state: frame store, load pointer, zigzag walker and open run
  // --------------------------------------------------------------------------
  logic [COEF_W-1:0] coef_store [DEPTH];
  logic [DIM_W-1:0]  width_reg;
  logic [DIM_W-1:0]  height_reg;
  int                ld_row, ld_col;
  int                sc_row, sc_col;
  bit                sc_active;
  bit                sc_up;
  bit                sc_first;
  logic [COEF_W-1:0] run_val;
  logic [RUN_W-1:0]  run_len;

  run_t pending_runs [$];   // run pairs still owed by the block, oldest first
  run_t oldest_run;

  int errors             = 0;
  int items_accepted     = 0;
  int ignored_items      = 0;
  int runs_checked       = 0;
  int frames_closed      = 0;
  int input_stall_cycles = 0;
  int burst_left         = 0;

  bit calm     = 1'b0;   // no sender gaps and no receiver stalls
  bit hold_req = 1'b0;   // ask the receiver for a long hold-off

  // Clamp a configured dimension to what the block actually uses
  function automatic int dim_in_use(input logic [DIM_W-1:0] raw, input int hi);
    if (int'(raw) < 2) return 2;
    if (int'(raw) > hi) return hi;
    return int'(raw);
  endfunction

  function automatic void restart_walk();
    sc_row   = 0;
    sc_col   = 0;
    sc_up    = 1'b1;
    sc_first = 1'b1;
    run_val  = '0;
    run_len  = '0;
  endfunction

  // Writes are taken only in the loading phase before a frame's first load
  function automatic void apply_write(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [DIM_W-1:0] value);
    if (sc_active || ld_row != 0 || ld_col != 0) return;
    case (idx)
      REG_FRAME_WIDTH:  width_reg  = value;
      REG_FRAME_HEIGHT: height_reg = value;
      default: ;
    endcase
  endfunction

  // Advance the predictor by one accepted item; return the run pairs it gives
  function automatic int zigzag_step(input logic cmd, input logic [COEF_W-1:0] coef,
                                     output run_t r0, output run_t r1);
    int w;
    int h;
    int n;
    logic [COEF_W-1:0] v;
    w  = dim_in_use(width_reg, STORE_COLS);
    h  = dim_in_use(height_reg, STORE_ROWS);
    n  = 0;
    r0 = '0;
    r1 = '0;
    if (cmd == CMD_LOAD) begin
      if (sc_active) return 0;
      coef_store[ld_row * STORE_COLS + ld_col] = coef;
      if (ld_col >= w - 1) begin
        ld_col = 0;
        if (ld_row >= h - 1) begin
          ld_row    = 0;
          sc_active = 1'b1;
          restart_walk();
        end else begin
          ld_row++;
        end
      end else begin
        ld_col++;
      end
      return 0;
    end
    if (!sc_active) return 0;

    v = coef_store[sc_row * STORE_COLS + sc_col];
    if (sc_first) begin
      run_val  = v;
      run_len  = 1;
      sc_first = 1'b0;
    end else if (v == run_val) begin
      if (run_len != RUN_MAX) run_len++;
    end else begin
      r0      = '{run_val, run_len, 1'b0};
      n       = 1;
      run_val = v;
      run_len = 1;
    end

    // Bottom-right corner closes the frame and returns to loading
    if (sc_row == h - 1 && sc_col == w - 1) begin
      if (n == 0) r0 = '{run_val, run_len, 1'b1};
      else        r1 = '{run_val, run_len, 1'b1};
      n++;
      sc_active = 1'b0;
      ld_row    = 0;
      ld_col    = 0;
      restart_walk();
      frames_closed++;
      return n;
    end

    // Zigzag walk: bounce off the edges, flipping direction
    if (sc_up) begin
      if (sc_col < w - 1) begin
        sc_col++;
        if (sc_row == 0) sc_up = 1'b0;
        else sc_row--;
      end else begin
        sc_row++;
        sc_up = 1'b0;
      end
    end else begin
      if (sc_row < h - 1) begin
        sc_row++;
        if (sc_col == 0) sc_up = 1'b1;
        else sc_col--;
      end else begin
        sc_col++;
        sc_up = 1'b1;
      end
    end
    return n;
  endfunction

  // --------------------------------------------------------------------------
  // Sender side. Every task here starts and ends at a falling edge.
  // --------------------------------------------------------------------------

  // Offer one item, hold it until the transfer, then record what it owes.
  // typed_n >= 0 replaces the predicted pairs by the typed-in ones.
  task automatic transfer_item(input logic cmd, input logic [COEF_W-1:0] coef,
                               input int typed_n, input run_t t0, input run_t t1);
    run_t p0;
    run_t p1;
    int   n;
    int   gap;
    in_valid       <= 1'b1;
    in_command     <= cmd;
    in_coefficient <= coef;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_accepted++;
    if ((cmd == CMD_LOAD) ? sc_active : !sc_active) ignored_items++;
    // Record right at the transfer edge: no pair can show up before the next one
    n = zigzag_step(cmd, coef, p0, p1);
    if (typed_n >= 0) begin
      n  = typed_n;
      p0 = t0;
      p1 = t1;
    end
    if (n > 0) pending_runs = {pending_runs, p0};
    if (n > 1) pending_runs = {pending_runs, p1};
    @(negedge clk);
    // Bursts of back-to-back items, then a random gap
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 15);
      if (!calm) begin
        gap = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 12) : $urandom_range(0, 3);
        if (gap > 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(negedge clk);
        end
      end
    end
  endtask

  // Drop valid, wait for every owed pair, then let the pipeline go quiet
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_runs.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    apply_write(idx, value);
    @(negedge clk);
  endtask

  function automatic logic [DIM_W-1:0] small_dim();
    // Mostly 2..9, sometimes below range to exercise the clamp
    if ($urandom_range(0, 7) == 0) return DIM_W'($urandom_range(0, 1));
    return DIM_W'($urandom_range(2, 9));
  endfunction

  // Configure, load and scan one whole frame. palette_n == 0 draws every
  // value fresh; otherwise values come from a small palette to build runs.
  task automatic encode_frame(input logic [DIM_W-1:0] w_raw, input logic [DIM_W-1:0] h_raw,
                              input int palette_n, input bit pressure);
    logic [COEF_W-1:0] palette [4];
    logic [COEF_W-1:0] v;
    logic [COEF_W-1:0] prev;
    int start;
    bit held;
    settle();
    write_reg(REG_FRAME_WIDTH, w_raw);
    write_reg(REG_FRAME_HEIGHT, h_raw);
    for (int i = 0; i < 4; i++) begin
      palette[i] = $urandom_range(0, 1) ? $urandom : ($urandom_range(0, 4) - 2);
    end
    calm  = pressure || ($urandom_range(0, 3) == 0);
    prev  = palette[0];
    start = frames_closed;
    held  = 1'b0;
    while (frames_closed == start) begin
      if ((sc_active || ld_row != 0 || ld_col != 0) && $urandom_range(0, 149) == 0) begin
        // Write while busy: the block must drop it
        settle();
        write_reg(CFG_IDX_W'($urandom_range(0, 1)), DIM_W'($urandom_range(0, 511)));
      end else if (!sc_active) begin
        if ($urandom_range(0, 19) == 0) begin
          transfer_item(CMD_TICK, $urandom, -1, '0, '0);   // tick while loading
        end else begin
          if (palette_n == 0) v = $urandom;
          else if ($urandom_range(0, 1) != 0) v = prev;
          else v = palette[$urandom_range(0, palette_n - 1)];
          prev = v;
          transfer_item(CMD_LOAD, v, -1, '0, '0);
        end
      end else begin
        if (pressure && !held) begin
          // Stall the receiver for a long stretch while ticks keep coming
          hold_req = 1'b1;
          held     = 1'b1;
        end
        if ($urandom_range(0, 19) == 0) transfer_item(CMD_LOAD, $urandom, -1, '0, '0);
        else transfer_item(CMD_TICK, $urandom, -1, '0, '0);
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Receiver side: its own stall pattern, plus one long hold-off on request
  // --------------------------------------------------------------------------
  initial begin
    int hold_left;
    int pat_left;
    int pat_period;
    int pat_duty;
    int pat_phase;
    hold_left  = 0;
    pat_left   = 0;
    pat_period = 1;
    pat_duty   = 0;
    pat_phase  = 0;
    out_stall  = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES - 1;
        out_stall <= 1'b1;
      end else if (calm) begin
        out_stall <= 1'b0;
      end else begin
        // Pick a new periodic pattern now and then; duty below the period
        if (pat_left == 0) begin
          pat_period = $urandom_range(1, 8);
          pat_duty   = $urandom_range(0, pat_period - 1);
          pat_left   = $urandom_range(32, 160);
          pat_phase  = 0;
        end
        pat_left--;
        out_stall <= (pat_phase < pat_duty);
        pat_phase = (pat_phase + 1) % pat_period;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result checker: compare each output transfer with the oldest owed pair
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_stall) input_stall_cycles++;
      if (out_valid && !out_stall) begin
        if (pending_runs.size() == 0) begin
          $error("unexpected run pair: value %0d length %0d last %0d",
                 out_run_value, out_run_length, out_frame_last);
          errors++;
        end else begin
          oldest_run = pending_runs.pop_front();
          runs_checked++;
          if (out_run_value !== oldest_run.value) begin
            $error("run_value: expected %0d, got %0d", $signed(oldest_run.value), out_run_value);
            errors++;
          end
          if (out_run_length !== oldest_run.length) begin
            $error("run_length: expected %0d, got %0d", oldest_run.length, out_run_length);
            errors++;
          end
          if (out_frame_last !== oldest_run.last) begin
            $error("frame_last: expected %0d, got %0d", oldest_run.last, out_frame_last);
            errors++;
          end
        end
      end
    end
  end

  // Watchdog, sized several times over the slowest legal run
  initial begin
    #2ms;
    $display("timeout: %0d run pairs still owed", pending_runs.size());
    $display("[zigzag_run_length_encoder] ERROR");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  step_row_t dir_rows [22];

  initial begin
    int random_start;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_command     = CMD_LOAD;
    in_coefficient = '0;
    cfg_we         = 1'b0;
    cfg_index      = REG_FRAME_WIDTH;
    cfg_data       = '0;

    width_reg  = DIM_RESET;
    height_reg = DIM_RESET;
    ld_row     = 0;
    ld_col     = 0;
    sc_active  = 1'b0;
    restart_walk();

    // Two 2x2 frames (dimensions clamped up from 1 and 0). The first has the
    // extreme values, a tick while loading, a load while scanning and a write
    // while scanning; the second a write while loading and a final tick that
    // closes two runs.
    dir_rows = '{
      '{ROW_WRITE, REG_FRAME_WIDTH,  32'd1,   0, '0, '0},
      '{ROW_WRITE, REG_FRAME_HEIGHT, 32'd0,   0, '0, '0},
      '{ROW_ITEM,  CMD_TICK, 32'hFFFF_FFFF,   0, '0, '0},
      '{ROW_ITEM,  CMD_LOAD, INT_MIN,         0, '0, '0},
      '{ROW_ITEM,  CMD_LOAD, INT_MIN,         0, '0, '0},
      '{ROW_ITEM,  CMD_LOAD, INT_MAX,         0, '0, '0},
      '{ROW_ITEM,  CMD_LOAD, INT_MAX,         0, '0, '0},
      '{ROW_ITEM,  CMD_TICK, 32'd0,           0, '0, '0},
      '{ROW_ITEM,  CMD_LOAD, 32'h1234_5678,   0, '0, '0},
      '{ROW_WRITE, REG_FRAME_WIDTH,  32'd200, 0, '0, '0},
      '{ROW_ITEM,  CMD_TICK, 32'hFFFF_FFFF,   0, '0, '0},
      '{ROW_ITEM,  CMD_TICK, 32'd0,           1, '{INT_MIN, 17'd2, 1'b0}, '0},
      '{ROW_ITEM,  CMD_TICK, 32'd0,           1, '{INT_MAX, 17'd2, 1'b1}, '0},
      '{ROW_ITEM,  CMD_LOAD, 32'd0,           0, '0, '0},
      '{ROW_WRITE, REG_FRAME_HEIGHT, 32'd100, 0, '0, '0},
      '{ROW_ITEM,  CMD_LOAD, 32'd5,           0, '0, '0},
      '{ROW_ITEM,  CMD_LOAD, 32'd5,           0, '0, '0},
      '{ROW_ITEM,  CMD_LOAD, 32'hFFFF_FFFF,   0, '0, '0},
      '{ROW_ITEM,  CMD_TICK, 32'd0,           0, '0, '0},
      '{ROW_ITEM,  CMD_TICK, 32'd0,           1, '{32'd0, 17'd1, 1'b0}, '0},
      '{ROW_ITEM,  CMD_TICK, 32'd0,           0, '0, '0},
      '{ROW_ITEM,  CMD_TICK, 32'd0,           2, '{32'd5, 17'd2, 1'b0},
                                                 '{32'hFFFF_FFFF, 17'd1, 1'b1}}
    };

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Walk the directed steps; writes only once the block has gone quiet
    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_WRITE) begin
        settle();
        write_reg(dir_rows[i].sel, dir_rows[i].data[DIM_W-1:0]);
      end else begin
        transfer_item(dir_rows[i].sel, dir_rows[i].data, dir_rows[i].nexp,
                      dir_rows[i].e0, dir_rows[i].e1);
      end
    end

    // Random frames; the second one is 8x8 of distinct values under a
    // long receiver hold-off, so the output queue fills and stalls the input
    random_start = items_accepted - ignored_items;
    for (int f = 0; items_accepted - ignored_items - random_start < RANDOM_ITEMS; f++) begin
      if (f == 1) encode_frame(9'd8, 9'd8, 0, 1'b1);
      else encode_frame(small_dim(), small_dim(), $urandom_range(1, 4), 1'b0);
    end

    // Extreme shape: a full-width strip, width clamped down from 511 and
    // height clamped up from 1
    encode_frame(9'd511, 9'd1, 3, 1'b0);

    settle();
    if (pending_runs.size() != 0) begin
      $error("%0d run pairs never arrived", pending_runs.size());
      errors++;
    end

    $display("Ran %0d frames, 2x2 up to a 256-column strip: %0d items in, %0d out of phase",
             frames_closed, items_accepted, ignored_items);
    $display("Checked %0d run pairs; input held by backpressure on %0d cycles",
             runs_checked, input_stall_cycles);
    if (errors == 0) begin
      $display("[zigzag_run_length_encoder] OK");
    end else begin
      $display("[zigzag_run_length_encoder] ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/zre_pkg.sv
design/zre_frame_store.sv
design/zre_walker.sv
design/zre_run_merge.sv
design/zigzag_run_length_encoder.sv
tb/zigzag_run_length_encoder_tb.sv
